// ===== src/ctn_pkg.sv =====
// shared types and constants for the capture ntp timestamper
// depends on nothing; used by ctn_ctrl, ctn_datapath and the top level
`default_nettype none

package ctn_pkg;

   // nanoseconds per second and per millisecond
   localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
   localparam logic [19:0] NS_PER_MS  = 20'd1000000;

   // one, two and three seconds in ns, for the quotient correction
   localparam logic [32:0] NS_1S = 33'd1000000000;
   localparam logic [32:0] NS_2S = 33'd2000000000;
   localparam logic [32:0] NS_3S = 33'd3000000000;

   // floor(2^61 / 1e9), shared by the seconds and fraction estimates
   localparam logic [31:0] RECIP_SEC = 32'd2305843009;

   localparam int          FRAME_MS_W     = 7;
   localparam logic [6:0]  FRAME_MS_RESET = 7'd20;
   localparam logic [26:0] FRAME_NS_RESET = 27'(FRAME_MS_RESET * NS_PER_MS);

   // division stages: seconds estimate, product, correction,
   // fraction estimate, product, correction
   localparam int                DIV_CYCLES = 6;
   localparam int                CYC_W      = $clog2(DIV_CYCLES);
   localparam logic [CYC_W-1:0]  DIV_LAST   = CYC_W'(DIV_CYCLES - 1);
   localparam logic [CYC_W-1:0]  CYC_STEP   = CYC_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REL,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

`default_nettype wire

// ===== src/ctn_ctrl.sv =====
// controller state machine for the capture ntp timestamper
// depends on ctn_pkg; drives ctn_datapath through cmd_type
`default_nettype none

module ctn_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output ctn_pkg::cmd_type         cmd,
   input  wire ctn_pkg::status_type status
);

   ctn_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctn_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ctn_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ctn_pkg::ST_REL;
            end
         end
         ctn_pkg::ST_REL: begin
            cmd.load = 1'b1;
            state_in = ctn_pkg::ST_DIV;
         end
         ctn_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = ctn_pkg::ST_OUT;
            end
         end
         ctn_pkg::ST_OUT: begin
            // output register free or being emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ctn_pkg::ST_IDLE;
            end
         end
         default: state_in = ctn_pkg::ST_IDLE;
      endcase
      rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/ctn_datapath.sv =====
// datapath: base latch, relative time, reciprocal division by 1e9 and final add
// depends on ctn_pkg; sequenced by ctn_ctrl
`default_nettype none

module ctn_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ctn_pkg::cmd_type    cmd,
   output ctn_pkg::status_type      status,
   input  wire logic                req_time_valid,
   input  wire logic [63:0]         req_time_ns,
   input  wire logic [63:0]         req_wall_ntp,
   input  wire logic                csr_valid,
   input  wire logic [6:0]          csr_frame_ms,
   output logic [63:0]              rsp_stamp_ntp
);

   logic                      started_ff;
   logic [26:0]               frame_ns_ff;
   logic [63:0]               base_ff;
   logic [63:0]               first_ff;
   logic [31:0]               count_ff;
   logic                      valid_ff;
   logic [63:0]               time_ff;
   logic [63:0]               rel_ff;
   logic [34:0]               qest_ff, qest_in;
   logic [32:0]               qprod_ff, qprod_in;
   logic [31:0]               sec_ff, sec_in;
   logic [29:0]               rem_ff, rem_in;
   logic [31:0]               fest_ff, fest_in;
   logic [33:0]               fprod_ff, fprod_in;
   logic [31:0]               frac_ff, frac_in;
   logic [ctn_pkg::CYC_W-1:0] cyc_ff;
   logic [63:0]               stamp_ff;
   logic [63:0]               rel;
   logic [58:0]               product;
   logic [65:0]               qmul;
   logic [60:0]               fmul;
   logic [32:0]               sec_rem;
   logic [33:0]               frac_rem;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff  <= 1'b0;
         frame_ns_ff <= ctn_pkg::FRAME_NS_RESET;
         count_ff    <= '0;
         base_ff     <= '0;
         first_ff    <= '0;
      end else begin
         // frame duration kept in ns, ready for a request taken on the same edge
         if (csr_valid) begin
            frame_ns_ff <= 27'(27'(csr_frame_ms) * 27'(ctn_pkg::NS_PER_MS));
         end
         if (cmd.capture && !started_ff) begin
            started_ff <= 1'b1;
            base_ff    <= req_wall_ntp;
            first_ff   <= req_time_valid ? req_time_ns : 64'd0;
            count_ff   <= '0;
         end
         if (cmd.load) begin
            count_ff <= count_ff + 32'd1;
         end
      end
   end

   assign product = 59'(59'(count_ff) * 59'(frame_ns_ff));

   always_comb begin
      if (!valid_ff) begin
         rel = 64'(product);
      end else if (time_ff >= first_ff) begin
         rel = time_ff - first_ff;
      end else begin
         rel = '0;
      end
   end

   // seconds estimate from the top 34 bits, at most 3 short of the quotient
   assign qmul     = 66'(rel_ff[63:30]) * 66'(ctn_pkg::RECIP_SEC);
   assign qest_in  = qmul[65:31];
   assign qprod_in = 33'(qest_ff[32:0]) * 33'(ctn_pkg::NS_PER_SEC);

   // remainder below 4e9, so 33 bits hold it exactly
   always_comb begin
      sec_rem = rel_ff[32:0] - qprod_ff;
      if (sec_rem >= ctn_pkg::NS_3S) begin
         sec_in = qest_ff[31:0] + 32'd3;
         rem_in = 30'(sec_rem - ctn_pkg::NS_3S);
      end else if (sec_rem >= ctn_pkg::NS_2S) begin
         sec_in = qest_ff[31:0] + 32'd2;
         rem_in = 30'(sec_rem - ctn_pkg::NS_2S);
      end else if (sec_rem >= ctn_pkg::NS_1S) begin
         sec_in = qest_ff[31:0] + 32'd1;
         rem_in = 30'(sec_rem - ctn_pkg::NS_1S);
      end else begin
         sec_in = qest_ff[31:0];
         rem_in = sec_rem[29:0];
      end
   end

   // fraction estimate floor(rem * 2^32 / 1e9), at most 1 short
   assign fmul     = 61'(rem_ff) * 61'(ctn_pkg::RECIP_SEC);
   assign fest_in  = fmul[60:29];
   assign fprod_in = 34'(fest_ff) * 34'(ctn_pkg::NS_PER_SEC);

   always_comb begin
      frac_rem = {rem_ff[1:0], 32'd0} - fprod_ff;
      if (frac_rem >= {1'b0, ctn_pkg::NS_2S}) begin
         frac_in = fest_ff + 32'd2;
      end else if (frac_rem >= {1'b0, ctn_pkg::NS_1S}) begin
         frac_in = fest_ff + 32'd1;
      end else begin
         frac_in = fest_ff;
      end
   end

   // payload registers; the stage registers flow each step and settle in order
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         valid_ff <= req_time_valid;
         time_ff  <= req_time_ns;
      end
      if (cmd.load) begin
         rel_ff <= rel;
         cyc_ff <= '0;
      end else if (cmd.step) begin
         qest_ff  <= qest_in;
         qprod_ff <= qprod_in;
         sec_ff   <= sec_in;
         rem_ff   <= rem_in;
         fest_ff  <= fest_in;
         fprod_ff <= fprod_in;
         frac_ff  <= frac_in;
         cyc_ff   <= cyc_ff + ctn_pkg::CYC_STEP;
      end
      // 64-bit add carries the fraction into seconds, which wrap at 32 bits
      if (cmd.finish) begin
         stamp_ff <= base_ff + {sec_ff, frac_ff};
      end
   end

   assign status.div_last = (cyc_ff == ctn_pkg::DIV_LAST);
   assign rsp_stamp_ntp   = stamp_ff;

endmodule

`default_nettype wire

// ===== src/capture_ntp_timestamper.sv =====
// capture ntp timestamper: a request taken in idle goes through relative time,
// division and output; the next request waits for idle, after the six division stages by 1e9
//   that use reciprocal multiplication with a small correction, seconds then fraction
// a finished stamp waits in the output register while the next request is taken
// synchronous active-high reset: frame_ms returns to 20, base not yet latched
// depends on ctn_pkg, ctn_ctrl and ctn_datapath
`default_nettype none

module capture_ntp_timestamper (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_time_valid,
   input  wire logic [63:0] req_time_ns,
   input  wire logic [63:0] req_wall_ntp,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_stamp_ntp,
   // configuration write channel (frame duration in ms)
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_frame_ms
);

   ctn_pkg::cmd_type    cmd;
   ctn_pkg::status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   // sequencing: idle, relative time, division, output
   ctn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic and state: base, first time, packet count, divider
   ctn_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_time_valid (req_time_valid),
      .req_time_ns    (req_time_ns),
      .req_wall_ntp   (req_wall_ntp),
      .csr_valid      (csr_valid),
      .csr_frame_ms   (csr_frame_ms),
      .rsp_stamp_ntp  (rsp_stamp_ntp)
   );

endmodule

`default_nettype wire
